// ===== hw/rtl/rcsp_pkg.sv =====
// Shared codes, characters and reset values for the request stream parser.
package rcsp_pkg;

    // Default widths
    localparam int COUNT_BITS_DEF = 21;
    localparam int LEN_BITS_DEF   = 30;

    // Configuration reset values
    localparam int MAX_COUNT_RESET = 1024 * 1024;
    localparam int MAX_LEN_RESET   = 512 * 1024 * 1024;

    // Configuration register indexes
    localparam logic REG_MAX_COUNT = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    // Framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // Per-byte result codes
    typedef enum logic [2:0] {
        EVT_FRAME    = 3'd0,
        EVT_PAYLOAD  = 3'd1,
        EVT_END      = 3'd2,
        EVT_NULL_END = 3'd3,
        EVT_ERROR    = 3'd4,
        EVT_IGNORED  = 3'd5,
        EVT_HEADER   = 3'd6
    } evt_code_t;

    // Status of the number line being parsed
    typedef struct packed {
        logic neg;
        logic digit_seen;
        logic bad;
    } line_flags_t;

endpackage

// ===== hw/rtl/rcsp_line_acc.sv =====
// Decimal line accumulator: takes one byte of a count or length line.
module rcsp_line_acc #(
    parameter int LEN_BITS = rcsp_pkg::LEN_BITS_DEF
) (
    input  logic [7:0]                byte_i,
    input  logic [LEN_BITS-1:0]       accum_i,
    input  rcsp_pkg::line_flags_t     flags_i,
    input  logic                      force_bad_i,
    output logic [LEN_BITS-1:0]       accum_o,
    output rcsp_pkg::line_flags_t     flags_o
);
    import rcsp_pkg::*;

    localparam int ACC_W = LEN_BITS + 4;
    localparam logic [LEN_BITS-1:0] LEN_MASK = '1;

    logic [ACC_W-1:0] acc_ext;
    logic [ACC_W-1:0] acc_x10;
    logic [ACC_W-1:0] acc_sum;

    // accum * 10 + digit, saturating at all ones
    assign acc_ext = {4'b0000, accum_i};
    assign acc_x10 = (acc_ext << 3) + (acc_ext << 1);
    assign acc_sum = acc_x10 + {{(ACC_W-4){1'b0}}, byte_i[3:0]};

    always_comb begin
        accum_o = accum_i;
        flags_o = flags_i;
        if (force_bad_i) begin
            flags_o.bad = 1'b1;
        end
        if (byte_i == CH_CR) begin
            // line end candidate: no change
        end else if (byte_i == CH_MINUS) begin
            if (flags_i.digit_seen || flags_i.neg) begin
                flags_o.bad = 1'b1;
            end else begin
                flags_o.neg = 1'b1;
            end
        end else if (byte_i inside {[CH_0:CH_9]}) begin
            accum_o = (acc_sum >= {4'b0000, LEN_MASK}) ? LEN_MASK : acc_sum[LEN_BITS-1:0];
            flags_o.digit_seen = 1'b1;
        end else begin
            flags_o.bad = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/rcsp_parser.sv =====
// Parser state machine: framing phases, limits, element counting and results.
module rcsp_parser #(
    parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF,
    parameter int LEN_BITS   = rcsp_pkg::LEN_BITS_DEF,
    parameter int CFG_W      = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take_i,
    input  logic [7:0]            byte_i,
    input  logic                  cfg_wr_en_i,
    input  logic                  cfg_index_i,
    input  logic [CFG_W-1:0]      cfg_data_i,
    output rcsp_pkg::evt_code_t   evt_o,
    output logic [COUNT_BITS-2:0] idx_o,
    output logic [LEN_BITS-1:0]   len_o,
    output logic                  done_o
);
    import rcsp_pkg::*;

    typedef enum logic [3:0] {
        PH_STAR, PH_CNT_LINE, PH_CNT_CR, PH_DOLLAR, PH_LEN_LINE,
        PH_LEN_CR, PH_PAYLOAD, PH_TRAIL_CR, PH_TRAIL_LF
    } phase_t;

    localparam logic [LEN_BITS-1:0] LEN_MASK = '1;
    localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);

    phase_t                phase_reg, phase_next;
    logic [LEN_BITS-1:0]   accum_reg, accum_next;
    line_flags_t           flags_reg, flags_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [COUNT_BITS-2:0] cur_reg, cur_next;
    logic [LEN_BITS-1:0]   pay_reg, pay_next;
    logic                  err_reg, err_next;
    logic [COUNT_BITS-1:0] max_count_reg;
    logic [LEN_BITS-1:0]   max_len_reg;

    logic [LEN_BITS-1:0]   acc_line;
    line_flags_t           flags_line;
    logic                  in_cr_phase;
    logic [COUNT_BITS-1:0] left_dec;
    logic [LEN_BITS-1:0]   pay_dec;
    logic [CFG_W-1:0]      accum_wide;
    logic [CFG_W-1:0]      max_count_wide;
    logic                  count_bad;

    assign in_cr_phase = (phase_reg == PH_CNT_CR) || (phase_reg == PH_LEN_CR);

    rcsp_line_acc #(.LEN_BITS(LEN_BITS)) u_line_acc (
        .byte_i      (byte_i),
        .accum_i     (accum_reg),
        .flags_i     (flags_reg),
        .force_bad_i (in_cr_phase),
        .accum_o     (acc_line),
        .flags_o     (flags_line)
    );

    assign left_dec       = left_reg - 1'b1;
    assign pay_dec        = pay_reg - 1'b1;
    assign accum_wide     = CFG_W'(accum_reg);
    assign max_count_wide = CFG_W'(max_count_reg);

    // Element count line checks
    assign count_bad = flags_reg.bad || !flags_reg.digit_seen || flags_reg.neg ||
                       (accum_reg == LEN_MASK) || (accum_reg == '0) ||
                       (accum_wide > max_count_wide);

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        pay_next   = pay_reg;
        err_next   = err_reg;
        evt_o      = EVT_FRAME;
        len_o      = '0;
        done_o     = 1'b0;

        if (err_reg) begin
            evt_o = EVT_IGNORED;
        end else begin
            case (phase_reg)
                PH_STAR: begin
                    if (byte_i == CH_STAR) begin
                        accum_next = '0;
                        flags_next = '0;
                        phase_next = PH_CNT_LINE;
                    end else begin
                        evt_o = EVT_ERROR;
                    end
                end
                PH_DOLLAR: begin
                    if (byte_i == CH_DOLLAR) begin
                        accum_next = '0;
                        flags_next = '0;
                        phase_next = PH_LEN_LINE;
                    end else begin
                        evt_o = EVT_ERROR;
                    end
                end
                PH_CNT_LINE, PH_LEN_LINE: begin
                    accum_next = acc_line;
                    flags_next = flags_line;
                    if (byte_i == CH_CR) begin
                        phase_next = (phase_reg == PH_CNT_LINE) ? PH_CNT_CR : PH_LEN_CR;
                    end
                end
                PH_CNT_CR: begin
                    if (byte_i != CH_LF) begin
                        // lone CR: bad line, keep parsing it
                        accum_next = acc_line;
                        flags_next = flags_line;
                        phase_next = (byte_i == CH_CR) ? PH_CNT_CR : PH_CNT_LINE;
                    end else if (count_bad) begin
                        evt_o = EVT_ERROR;
                    end else begin
                        left_next  = accum_wide[COUNT_BITS-1:0];
                        cur_next   = '0;
                        phase_next = PH_DOLLAR;
                    end
                end
                PH_LEN_CR: begin
                    if (byte_i != CH_LF) begin
                        accum_next = acc_line;
                        flags_next = flags_line;
                        phase_next = (byte_i == CH_CR) ? PH_LEN_CR : PH_LEN_LINE;
                    end else if (flags_reg.bad || !flags_reg.digit_seen ||
                                 accum_reg == LEN_MASK) begin
                        evt_o = EVT_ERROR;
                    end else if (flags_reg.neg && accum_reg == LEN_ONE) begin
                        // null element closes at once
                        evt_o     = EVT_NULL_END;
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            cur_next   = '0;
                            phase_next = PH_STAR;
                            done_o     = 1'b1;
                        end else begin
                            cur_next   = cur_reg + 1'b1;
                            phase_next = PH_DOLLAR;
                        end
                    end else if ((flags_reg.neg && accum_reg != '0) ||
                                 accum_reg > max_len_reg) begin
                        evt_o = EVT_ERROR;
                    end else begin
                        evt_o      = EVT_HEADER;
                        len_o      = accum_reg;
                        pay_next   = accum_reg;
                        phase_next = (accum_reg == '0) ? PH_TRAIL_CR : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    evt_o    = EVT_PAYLOAD;
                    pay_next = pay_dec;
                    if (pay_dec == '0) begin
                        phase_next = PH_TRAIL_CR;
                    end
                end
                PH_TRAIL_CR: begin
                    flags_next.bad = (byte_i != CH_CR);
                    phase_next     = PH_TRAIL_LF;
                end
                PH_TRAIL_LF: begin
                    if (flags_reg.bad || byte_i != CH_LF) begin
                        evt_o = EVT_ERROR;
                    end else begin
                        evt_o     = EVT_END;
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            cur_next   = '0;
                            phase_next = PH_STAR;
                            done_o     = 1'b1;
                        end else begin
                            cur_next   = cur_reg + 1'b1;
                            phase_next = PH_DOLLAR;
                        end
                    end
                end
                default: begin
                    evt_o = EVT_ERROR;
                end
            endcase
            if (evt_o == EVT_ERROR) begin
                err_next = 1'b1;
            end
        end
    end

    assign idx_o = cur_reg;

    // State and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STAR;
            accum_reg     <= '0;
            flags_reg     <= '0;
            left_reg      <= '0;
            cur_reg       <= '0;
            pay_reg       <= '0;
            err_reg       <= 1'b0;
            max_count_reg <= COUNT_BITS'(MAX_COUNT_RESET);
            max_len_reg   <= LEN_BITS'(MAX_LEN_RESET);
        end else begin
            if (take_i) begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                flags_reg <= flags_next;
                left_reg  <= left_next;
                cur_reg   <= cur_next;
                pay_reg   <= pay_next;
                err_reg   <= err_next;
            end
            if (cfg_wr_en_i) begin
                if (cfg_index_i == REG_MAX_COUNT) begin
                    max_count_reg <= cfg_data_i[COUNT_BITS-1:0];
                end else if (cfg_index_i == REG_MAX_LEN) begin
                    max_len_reg <= cfg_data_i[LEN_BITS-1:0];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/rcsp_out_buf.sv =====
// Output register with skid stage so the input side can take one more item under stall.
module rcsp_out_buf #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              in_take;
    logic              out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_take;
            skid_valid_reg <= 1'b0;
        end else if (in_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Data
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_take) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== hw/rtl/resp_command_stream_parser_core.sv =====
// Top level of the request stream parser: byte parser and result buffer.
//
//  Channel   Direction  Handshake         Carries
//  s_        in         s_valid/s_ready   s_in_byte, one stream byte
//  m_        out        m_valid/m_ready   one result per byte
//  cfg_      in         cfg_wr_en         max_array_count, max_string_length
//
// One byte per cycle while m_ does not stall: a byte is parsed in the cycle
// it is taken and its result is registered in the output register. Reset
// restores the limits to their defaults. While m_ stalls, one more byte is
// taken into the skid stage; s_ready then drops until the stall clears.
module resp_command_stream_parser_core #(
    parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF,
    parameter int LEN_BITS   = rcsp_pkg::LEN_BITS_DEF,
    parameter int CFG_W      = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_event_res,
    output logic [7:0]            m_data_byte,
    output logic [COUNT_BITS-2:0] m_element_index,
    output logic [LEN_BITS-1:0]   m_element_length,
    output logic                  m_request_done,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);
    import rcsp_pkg::*;

    localparam int RES_W = 3 + 8 + (COUNT_BITS - 1) + LEN_BITS + 1;

    evt_code_t             evt;
    logic [COUNT_BITS-2:0] idx;
    logic [LEN_BITS-1:0]   len;
    logic                  done;
    logic                  take;
    logic [RES_W-1:0]      res_in;
    logic [RES_W-1:0]      res_out;

    assign take = s_valid && s_ready;

    rcsp_parser #(
        .COUNT_BITS (COUNT_BITS),
        .LEN_BITS   (LEN_BITS),
        .CFG_W      (CFG_W)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take_i      (take),
        .byte_i      (s_in_byte),
        .cfg_wr_en_i (cfg_wr_en),
        .cfg_index_i (cfg_index),
        .cfg_data_i  (cfg_data),
        .evt_o       (evt),
        .idx_o       (idx),
        .len_o       (len),
        .done_o      (done)
    );

    // Pack one result for the output buffer
    assign res_in = {evt, s_in_byte, idx, len, done};

    rcsp_out_buf #(.DATA_W(RES_W)) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign {m_event_res, m_data_byte, m_element_index, m_element_length, m_request_done} =
        res_out;

endmodule

// ===== hw/rtl/rcsp_checker.sv =====
// Port-level checks for the request stream parser, bound to the top level.
module rcsp_checker #(
    parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF,
    parameter int LEN_BITS   = rcsp_pkg::LEN_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [2:0]            m_event_res,
    input logic [7:0]            m_data_byte,
    input logic [COUNT_BITS-2:0] m_element_index,
    input logic [LEN_BITS-1:0]   m_element_length,
    input logic                  m_request_done
);
    import rcsp_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) &&
        $stable(m_data_byte) && $stable(m_element_index) &&
        $stable(m_element_length) && $stable(m_request_done))
        else $error("result changed under stall");

    // Request end only on an element end
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_request_done |->
        m_event_res == EVT_END || m_event_res == EVT_NULL_END)
        else $error("request_done without element end");

    // Length shows only with a header
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EVT_HEADER |-> m_element_length == '0)
        else $error("element_length set outside header");

    // The transfer after an error is ignored
    a_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_event_res == EVT_ERROR || m_event_res == EVT_IGNORED)
        |=> !m_valid || m_event_res == EVT_IGNORED)
        else $error("result after error not ignored");

endmodule

bind resp_command_stream_parser_core rcsp_checker #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
) u_rcsp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_res      (m_event_res),
    .m_data_byte      (m_data_byte),
    .m_element_index  (m_element_index),
    .m_element_length (m_element_length),
    .m_request_done   (m_request_done)
);

// ===== test/resp_command_stream_parser_core_tb.sv =====
// Self-checking testbench for the request stream parser core, predicted byte by byte.
`timescale 1ns / 100ps

module resp_command_stream_parser_core_tb;
    import rcsp_pkg::*;

    localparam int IDX_W = COUNT_BITS_DEF - 1;
    localparam int LEN_W = LEN_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [LEN_W-1:0] ACCUM_SAT = '1;
    localparam string CRLF = "\015\012";

    // Parser phases of the predictor
    typedef enum logic [3:0] {
        PS_STAR, PS_CNT_LINE, PS_CNT_CR, PS_DOLLAR, PS_LEN_LINE,
        PS_LEN_CR, PS_PAYLOAD, PS_TRAIL_CR, PS_TRAIL_LF
    } parse_phase_t;

    typedef struct packed {
        evt_code_t             ev;
        logic [7:0]            byte_val;
        logic [IDX_W-1:0]      elem_idx;
        logic [LEN_W-1:0]      elem_len;
        logic                  req_done;
    } byte_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_in_byte;
    logic                        m_valid;
    logic                        m_ready;
    logic [2:0]                  m_event_res;
    logic [7:0]                  m_data_byte;
    logic [IDX_W-1:0]            m_element_index;
    logic [LEN_W-1:0]            m_element_length;
    logic                        m_request_done;
    logic                        cfg_wr_en;
    logic                        cfg_index;
    logic [LEN_W-1:0]            cfg_data;

    // Predictor state and its copy of the limits
    parse_phase_t                pr_phase;
    logic [LEN_W-1:0]            pr_accum;
    logic                        pr_neg;
    logic                        pr_digit;
    logic                        pr_bad;
    logic [COUNT_BITS_DEF-1:0]   pr_left;
    logic [IDX_W-1:0]            pr_elem;
    logic [LEN_W-1:0]            pr_payload;
    logic                        pr_err;
    logic [COUNT_BITS_DEF-1:0]   lim_count;
    logic [LEN_W-1:0]            lim_len;

    byte_result_t                pending_results[$];
    bit                          pace_on;
    int                          hold_len;
    int                          fail_cnt;
    int                          bytes_sent;
    int                          stall_cycles;
    int                          n_requests, n_headers, n_nulls, n_payload, n_ignored;
    string                       err_case_name;

    resp_command_stream_parser_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_data_byte      (m_data_byte),
        .m_element_index  (m_element_index),
        .m_element_length (m_element_length),
        .m_request_done   (m_request_done),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void clear_line();
        pr_accum = '0;
        pr_neg   = 1'b0;
        pr_digit = 1'b0;
        pr_bad   = 1'b0;
    endfunction

    // One character of a number line other than its closing LF
    function automatic void take_line_char(input logic [7:0] b, input parse_phase_t line_ph,
                                           input parse_phase_t cr_ph);
        logic [LEN_W+3:0] wide;
        if (b == CH_CR) begin
            pr_phase = cr_ph;
            return;
        end
        pr_phase = line_ph;
        if (b == CH_MINUS) begin
            if (pr_digit || pr_neg)
                pr_bad = 1'b1;
            else
                pr_neg = 1'b1;
        end else if (b >= CH_0 && b <= CH_9) begin
            wide = {4'd0, pr_accum} * 34'd10 + (b - CH_0);
            pr_accum = (wide >= ACCUM_SAT) ? ACCUM_SAT : wide[LEN_W-1:0];
            pr_digit = 1'b1;
        end else begin
            pr_bad = 1'b1;
        end
    endfunction

    // Returns 1 when the element just closed was the last one of the request
    function automatic bit close_element();
        pr_left = pr_left - 1'b1;
        if (pr_left == '0) begin
            pr_elem  = '0;
            pr_phase = PS_STAR;
            return 1'b1;
        end
        pr_elem  = pr_elem + 1'b1;
        pr_phase = PS_DOLLAR;
        return 1'b0;
    endfunction

    function automatic byte_result_t parse_byte(input logic [7:0] b);
        byte_result_t r;
        r.ev       = EVT_FRAME;
        r.byte_val = b;
        r.elem_idx = pr_elem;
        r.elem_len = '0;
        r.req_done = 1'b0;
        if (pr_err) begin
            r.ev = EVT_IGNORED;
        end else begin
            case (pr_phase)
                PS_STAR: begin
                    if (b == CH_STAR) begin
                        clear_line();
                        pr_phase = PS_CNT_LINE;
                    end else begin
                        r.ev = EVT_ERROR;
                    end
                end
                PS_DOLLAR: begin
                    if (b == CH_DOLLAR) begin
                        clear_line();
                        pr_phase = PS_LEN_LINE;
                    end else begin
                        r.ev = EVT_ERROR;
                    end
                end
                PS_CNT_LINE: begin
                    take_line_char(b, PS_CNT_LINE, PS_CNT_CR);
                end
                PS_LEN_LINE: begin
                    take_line_char(b, PS_LEN_LINE, PS_LEN_CR);
                end
                PS_CNT_CR: begin
                    // a CR not followed by LF spoils the line
                    if (b != CH_LF) begin
                        pr_bad = 1'b1;
                        take_line_char(b, PS_CNT_LINE, PS_CNT_CR);
                    end else if (pr_bad || !pr_digit || pr_neg || pr_accum == ACCUM_SAT ||
                                 pr_accum == '0 || pr_accum > lim_count) begin
                        r.ev = EVT_ERROR;
                    end else begin
                        pr_left  = pr_accum[COUNT_BITS_DEF-1:0];
                        pr_elem  = '0;
                        pr_phase = PS_DOLLAR;
                    end
                end
                PS_LEN_CR: begin
                    if (b != CH_LF) begin
                        pr_bad = 1'b1;
                        take_line_char(b, PS_LEN_LINE, PS_LEN_CR);
                    end else if (pr_bad || !pr_digit || pr_accum == ACCUM_SAT) begin
                        r.ev = EVT_ERROR;
                    end else if (pr_neg && pr_accum == 1) begin
                        r.ev       = EVT_NULL_END;
                        r.req_done = close_element();
                    end else if ((pr_neg && pr_accum != 0) || pr_accum > lim_len) begin
                        r.ev = EVT_ERROR;
                    end else begin
                        r.ev       = EVT_HEADER;
                        r.elem_len = pr_accum;
                        pr_payload = pr_accum;
                        pr_phase   = (pr_accum == 0) ? PS_TRAIL_CR : PS_PAYLOAD;
                    end
                end
                PS_PAYLOAD: begin
                    r.ev = EVT_PAYLOAD;
                    pr_payload = pr_payload - 1'b1;
                    if (pr_payload == '0)
                        pr_phase = PS_TRAIL_CR;
                end
                PS_TRAIL_CR: begin
                    pr_bad   = (b != CH_CR);
                    pr_phase = PS_TRAIL_LF;
                end
                PS_TRAIL_LF: begin
                    if (pr_bad || b != CH_LF) begin
                        r.ev = EVT_ERROR;
                    end else begin
                        r.ev       = EVT_END;
                        r.req_done = close_element();
                    end
                end
                default: begin
                    r.ev = EVT_ERROR;
                end
            endcase
            if (r.ev == EVT_ERROR)
                pr_err = 1'b1;
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // Decimal text, now and then with leading zeros
    function automatic string num_text(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            s = {"0", s};
        return s;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pace_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.insert(pending_results.size(), parse_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Limits change only with the parser idle
    task automatic set_limits(input int unsigned cnt, input int unsigned len);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_COUNT;
        cfg_data  <= LEN_W'(cnt);
        @(posedge aclk);
        lim_count = COUNT_BITS_DEF'(cnt);
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= LEN_W'(len);
        @(posedge aclk);
        lim_len = LEN_W'(len);
        cfg_wr_en <= 1'b0;
    endtask

    // Well-formed request with random shape and content, sized to the current limits
    task automatic send_random_request(input bit paced);
        int unsigned n_elem, cap, len, kind, pick;
        string sign;
        pace_on = paced && ($urandom_range(0, 3) != 0);
        cap = (lim_count < 6) ? lim_count : 6;
        n_elem = $urandom_range(1, cap);
        if (lim_count <= 8 && $urandom_range(0, 2) == 0)
            n_elem = lim_count;
        push_byte(CH_STAR);
        send_text({num_text(n_elem), CRLF});
        repeat (n_elem) begin
            push_byte(CH_DOLLAR);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // minus one: null element, no payload or trailer
                send_text({"-", num_text(1), CRLF});
            end else begin
                if (kind == 1) begin
                    len = 0;
                end else begin
                    len = $urandom_range(0, (lim_len < 12) ? lim_len : 12);
                    if (lim_len <= 40 && $urandom_range(0, 2) == 0)
                        len = lim_len;
                end
                sign = "";
                if (len == 0 && $urandom_range(0, 1) != 0)
                    sign = "-";
                send_text({sign, num_text(len), CRLF});
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        push_byte(CH_CR);
                    else if (pick == 1)
                        push_byte(CH_LF);
                    else
                        push_byte(8'($urandom_range(0, 255)));
                end
                send_text(CRLF);
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_forms();
        pace_on = 1'b1;
        // null element, then payload at both byte extremes, closing the request
        send_text({"*2", CRLF, "$-1", CRLF, "$2", CRLF});
        push_byte(8'h00);
        push_byte(8'hFF);
        send_text(CRLF);
        // minus zero is an empty payload
        send_text({"*1", CRLF, "$-0", CRLF, CRLF});
    endtask

    task automatic test_limit_sweep();
        int target;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0: set_limits(MAX_COUNT_RESET, MAX_LEN_RESET);
                1: set_limits(1, 0);
                2: set_limits(3, 5);
                3: set_limits($urandom_range(1, 8), $urandom_range(0, 40));
                4: set_limits(MAX_COUNT_RESET, 1);
                default: set_limits($urandom_range(2, 64), $urandom_range(41, 2000));
            endcase
            target = bytes_sent + 100;
            while (bytes_sent < target)
                send_random_request(1'b1);
        end
    endtask

    // Sink stalls for a long stretch while the source keeps pushing
    task automatic test_backpressure();
        int target;
        set_limits(MAX_COUNT_RESET, MAX_LEN_RESET);
        hold_len = 60;
        target = bytes_sent + 40;
        while (bytes_sent < target)
            send_random_request(1'b0);
    endtask

    // One malformed input per run, then noise that must be ignored
    task automatic test_error_latch();
        logic [7:0] b;
        int unsigned kind, pick;
        pace_on = 1'b1;
        kind = $urandom_range(0, 15);
        case (kind)
            0: begin
                err_case_name = "wrong request marker";
                do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
                push_byte(b);
            end
            1: begin
                err_case_name = "wrong element marker";
                send_text({"*1", CRLF});
                do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR);
                push_byte(b);
            end
            2: begin
                err_case_name = "minus after digit";
                send_text({"*1", CRLF, "$1-", CRLF});
            end
            3: begin
                err_case_name = "double minus";
                send_text({"*--1", CRLF});
            end
            4: begin
                err_case_name = "non-digit in count";
                send_text({"*2x", CRLF});
            end
            5: begin
                err_case_name = "empty count line";
                send_text({"*", CRLF});
            end
            6: begin
                err_case_name = "lone minus length";
                send_text({"*1", CRLF, "$-", CRLF});
            end
            7: begin
                err_case_name = "lone CR";
                send_text({"*1", "\015", "5", CRLF});
            end
            8: begin
                err_case_name = "zero count";
                send_text({"*0", CRLF});
            end
            9: begin
                err_case_name = "minus zero count";
                send_text({"*-0", CRLF});
            end
            10: begin
                err_case_name = "count above limit";
                send_text({"*", num_text(lim_count + 32'd1), CRLF});
            end
            11: begin
                err_case_name = "saturated count";
                send_text({"*99999999999", CRLF});
            end
            12: begin
                err_case_name = "negative length";
                send_text({"*1", CRLF, "$-2", CRLF});
            end
            13: begin
                err_case_name = "length above limit";
                send_text({"*1", CRLF, "$", num_text(lim_len + 32'd1), CRLF});
            end
            14: begin
                err_case_name = "saturated length";
                send_text({"*1", CRLF, "$1073741823", CRLF});
            end
            default: begin
                err_case_name = "bad payload trailer";
                send_text({"*1", CRLF, "$1", CRLF, "Z"});
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    push_byte(CH_CR);
                    push_byte("Z");
                end else if (pick == 1) begin
                    push_byte("Z");
                    push_byte(CH_LF);
                end else begin
                    push_byte("Z");
                    push_byte("Z");
                end
            end
        endcase
        repeat (30) push_byte(8'($urandom_range(0, 255)));
    endtask

    // ---------------- result side ----------------

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            stall = pace_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        byte_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("%0t: result with nothing pending: ev=%0d byte=%02h", $realtime,
                             m_event_res, m_data_byte);
            end else begin
                want = pending_results.pop_front();
                if (m_event_res !== want.ev || m_data_byte !== want.byte_val ||
                    m_element_index !== want.elem_idx || m_element_length !== want.elem_len ||
                    m_request_done !== want.req_done) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"%0t: mismatch exp ev=%0d byte=%02h idx=%0d len=%0d done=%0d",
                                  " got ev=%0d byte=%02h idx=%0d len=%0d done=%0d"}, $realtime,
                                 want.ev, want.byte_val, want.elem_idx, want.elem_len,
                                 want.req_done, m_event_res, m_data_byte, m_element_index,
                                 m_element_length, m_request_done);
                end
                case (want.ev)
                    EVT_HEADER:   n_headers++;
                    EVT_NULL_END: n_nulls++;
                    EVT_PAYLOAD:  n_payload++;
                    EVT_IGNORED:  n_ignored++;
                    default: ;
                endcase
                if (want.req_done)
                    n_requests++;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MAX_COUNT;
        cfg_data  = '0;
        pace_on   = 1'b1;
        hold_len  = 0;
        fail_cnt  = 0;
        bytes_sent = 0;
        stall_cycles = 0;
        n_requests = 0;
        n_headers  = 0;
        n_nulls    = 0;
        n_payload  = 0;
        n_ignored  = 0;
        err_case_name = "";
        pr_phase   = PS_STAR;
        clear_line();
        pr_left    = '0;
        pr_elem    = '0;
        pr_payload = '0;
        pr_err     = 1'b0;
        lim_count  = MAX_COUNT_RESET;
        lim_len    = MAX_LEN_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_forms();
        test_limit_sweep();
        test_backpressure();
        test_error_latch();
        wait_drained();

        $display("Covered %0d bytes: %0d requests closed, %0d headers, %0d null elements,",
                 bytes_sent, n_requests, n_headers, n_nulls);
        $display("%0d payload bytes over 7 limit settings; error path '%s', %0d bytes ignored.",
                 n_payload, err_case_name, n_ignored);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rcsp_pkg.sv
hw/rtl/rcsp_line_acc.sv
hw/rtl/rcsp_parser.sv
hw/rtl/rcsp_out_buf.sv
hw/rtl/resp_command_stream_parser_core.sv
hw/rtl/rcsp_checker.sv
test/resp_command_stream_parser_core_tb.sv
